### sv/assert_macros.svh
// Assertion macros shared by the limiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SWLL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SWLL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/swll_pkg.sv
// Shared types, constants and codes of the sidechain lookahead limiter.
`default_nettype none

package swll_pkg;

   // Field and datapath widths
   localparam int SAMPLE_BITS    = 24;
   localparam int FILT_BITS      = 28;
   localparam int COEF_BITS      = 26;
   localparam int GAIN_BITS      = 24;
   localparam int MIX_BITS       = 17;
   localparam int CSR_DATA_BITS  = 26;
   localparam int CSR_INDEX_BITS = 3;
   localparam int MUL_A_BITS     = 26;
   localparam int MUL_B_BITS     = 28;
   localparam int PROD_BITS      = MUL_A_BITS + MUL_B_BITS;
   localparam int ACC_BITS       = 58;
   localparam int MUL_SEL_BITS   = 5;

   // Unity gain (Q1.23) and unity mix (Q1.16)
   localparam logic [GAIN_BITS-1:0] GAIN_ONE = 24'd8388608;
   localparam logic [MIX_BITS-1:0]  MIX_ONE  = 17'd65536;

   // Register reset values
   localparam logic signed [COEF_BITS-1:0] B0_RESET      = 26'sd4194304;
   localparam logic [GAIN_BITS-1:0]        CEILING_RESET = 24'd7476355;
   localparam logic [GAIN_BITS-1:0]        RELEASE_RESET = 24'd16770227;
   localparam logic [MIX_BITS-1:0]         MIX_RESET     = 17'd65536;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BELL_B0        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BELL_B1        = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BELL_B2        = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BELL_A1        = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BELL_A2        = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CEILING_LINEAR = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE_COEFF  = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WET_MIX        = 3'd7;

   // Multiplier operand selects; the ten filter products run in this order
   localparam logic [MUL_SEL_BITS-1:0] MS_B0XL  = 5'd0;
   localparam logic [MUL_SEL_BITS-1:0] MS_B1XL1 = 5'd1;
   localparam logic [MUL_SEL_BITS-1:0] MS_B2XL2 = 5'd2;
   localparam logic [MUL_SEL_BITS-1:0] MS_A1YL1 = 5'd3;
   localparam logic [MUL_SEL_BITS-1:0] MS_A2YL2 = 5'd4;
   localparam logic [MUL_SEL_BITS-1:0] MS_B0XR  = 5'd5;
   localparam logic [MUL_SEL_BITS-1:0] MS_B1XR1 = 5'd6;
   localparam logic [MUL_SEL_BITS-1:0] MS_B2XR2 = 5'd7;
   localparam logic [MUL_SEL_BITS-1:0] MS_A1YR1 = 5'd8;
   localparam logic [MUL_SEL_BITS-1:0] MS_A2YR2 = 5'd9;
   localparam logic [MUL_SEL_BITS-1:0] MS_REL   = 5'd10;
   localparam logic [MUL_SEL_BITS-1:0] MS_WETL  = 5'd11;
   localparam logic [MUL_SEL_BITS-1:0] MS_WETR  = 5'd12;
   localparam logic [MUL_SEL_BITS-1:0] MS_MIXWL = 5'd13;
   localparam logic [MUL_SEL_BITS-1:0] MS_MIXAL = 5'd14;
   localparam logic [MUL_SEL_BITS-1:0] MS_MIXWR = 5'd15;
   localparam logic [MUL_SEL_BITS-1:0] MS_MIXAR = 5'd16;

   // Accumulator operations
   localparam logic [1:0] ACC_NONE = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;
   localparam logic [1:0] ACC_SUB  = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] audio_left;
      logic signed [SAMPLE_BITS-1:0] audio_right;
      logic signed [SAMPLE_BITS-1:0] side_left;
      logic signed [SAMPLE_BITS-1:0] side_right;
      logic                          block_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] limited_left;
      logic signed [SAMPLE_BITS-1:0] limited_right;
      logic [GAIN_BITS-1:0]          gain_applied;
      logic                          block_end_out;
   } rsp_payload_type;

   // Controller to datapath commands
   typedef struct packed {
      logic                    load_in;
      logic [MUL_SEL_BITS-1:0] mul_sel;
      logic [1:0]              acc_op;
      logic                    acc_ch;
      logic                    filt_done;
      logic                    peak_en;
      logic                    div_init;
      logic                    div_step;
      logic                    want_en;
      logic                    gain_en;
      logic                    wet_en;
      logic                    out_load;
   } swll_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic limit;
   } swll_status_type;

endpackage

`default_nettype wire

### sv/swll_chan_if.sv
// Valid/ready channel interface carrying one payload beat.
`default_nettype none

interface swll_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/swll_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module swll_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

### sv/swll_ctrl.sv
// Sequencing state machine of the limiter: issues datapath commands per item.
`default_nettype none

module swll_ctrl import swll_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire swll_status_type status,
   output swll_cmd_type         cmd
);
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_FILT = 4'd1;
   localparam logic [3:0] ST_FOUT = 4'd2;
   localparam logic [3:0] ST_PEAK = 4'd3;
   localparam logic [3:0] ST_DIVI = 4'd4;
   localparam logic [3:0] ST_DIV  = 4'd5;
   localparam logic [3:0] ST_WANT = 4'd6;
   localparam logic [3:0] ST_REL  = 4'd7;
   localparam logic [3:0] ST_RELW = 4'd8;
   localparam logic [3:0] ST_GAIN = 4'd9;
   localparam logic [3:0] ST_WET  = 4'd10;
   localparam logic [3:0] ST_WETR = 4'd11;
   localparam logic [3:0] ST_MIX  = 4'd12;
   localparam logic [3:0] ST_DONE = 4'd13;

   localparam logic [4:0] TAPS      = 5'd5;
   localparam logic [4:0] FILT_LAST = 5'd10;
   localparam logic [4:0] DIV_LAST  = 5'd23;
   localparam logic [4:0] WET_LAST  = 5'd2;
   localparam logic [4:0] MIX_LAST  = 5'd4;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [4:0] tap;

   // Next state and command decode
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff + 5'd1;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      tap       = (cnt_ff < TAPS) ? cnt_ff : cnt_ff - TAPS;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_FILT;
            end
         end
         ST_FILT: begin
            // ten products, left filter then right; last count drains
            if (cnt_ff < FILT_LAST) begin
               cmd.mul_sel = MS_B0XL + cnt_ff;
               cmd.acc_ch  = (cnt_ff >= TAPS);
               case (tap) inside
                  5'd0:       cmd.acc_op = ACC_LOAD;
                  5'd1, 5'd2: cmd.acc_op = ACC_ADD;
                  default:    cmd.acc_op = ACC_SUB;
               endcase
            end else begin
               state_in = ST_FOUT;
            end
         end
         ST_FOUT: begin
            cmd.filt_done = 1'b1;
            state_in      = ST_PEAK;
         end
         ST_PEAK: begin
            cmd.peak_en = 1'b1;
            state_in    = ST_DIVI;
         end
         ST_DIVI: begin
            cnt_in = '0;
            if (status.limit) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end else begin
               state_in = ST_WANT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_WANT;
            end
         end
         ST_WANT: begin
            cmd.want_en = 1'b1;
            state_in    = ST_REL;
         end
         ST_REL: begin
            cmd.mul_sel = MS_REL;
            cmd.acc_op  = ACC_LOAD;
            state_in    = ST_RELW;
         end
         ST_RELW: begin
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.gain_en = 1'b1;
            cnt_in      = '0;
            state_in    = ST_WET;
         end
         ST_WET: begin
            case (cnt_ff)
               5'd0: begin
                  cmd.mul_sel = MS_WETL;
                  cmd.acc_op  = ACC_LOAD;
               end
               5'd1: begin
                  cmd.mul_sel = MS_WETR;
                  cmd.acc_op  = ACC_LOAD;
                  cmd.acc_ch  = 1'b1;
               end
               default: begin
               end
            endcase
            if (cnt_ff == WET_LAST) begin
               state_in = ST_WETR;
            end
         end
         ST_WETR: begin
            cmd.wet_en = 1'b1;
            cnt_in     = '0;
            state_in   = ST_MIX;
         end
         ST_MIX: begin
            case (cnt_ff)
               5'd0: begin
                  cmd.mul_sel = MS_MIXWL;
                  cmd.acc_op  = ACC_LOAD;
               end
               5'd1: begin
                  cmd.mul_sel = MS_MIXAL;
                  cmd.acc_op  = ACC_ADD;
               end
               5'd2: begin
                  cmd.mul_sel = MS_MIXWR;
                  cmd.acc_op  = ACC_LOAD;
                  cmd.acc_ch  = 1'b1;
               end
               5'd3: begin
                  cmd.mul_sel = MS_MIXAR;
                  cmd.acc_op  = ACC_ADD;
                  cmd.acc_ch  = 1'b1;
               end
               default: begin
               end
            endcase
            if (cnt_ff == MIX_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result beat valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

`default_nettype wire

### sv/swll_dp.sv
// Limiter datapath: registers, shared multiplier, accumulators, divider, delay ring.
`default_nettype none

module swll_dp import swll_pkg::*; #(
   parameter int LOOKAHEAD_DEPTH = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   input  wire req_payload_type           req_payload,
   input  wire swll_cmd_type              cmd,
   output swll_status_type                status,
   output rsp_payload_type                rsp_payload
);
   localparam int PTR_W = (LOOKAHEAD_DEPTH > 1) ? $clog2(LOOKAHEAD_DEPTH) : 1;
   localparam int RAM_W = 2 * SAMPLE_BITS;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LOOKAHEAD_DEPTH - 1);

   localparam logic signed [ACC_BITS-1:0] FILT_RND = ACC_BITS'(1) << 21;
   localparam logic signed [ACC_BITS-1:0] REL_RND  = ACC_BITS'(1) << 23;
   localparam logic signed [ACC_BITS-1:0] WET_RND  = ACC_BITS'(1) << 22;
   localparam logic signed [ACC_BITS-1:0] OUT_RND  = ACC_BITS'(1) << 15;
   localparam logic signed [ACC_BITS-1:0] FILT_HI  =
      (ACC_BITS'(1) << (FILT_BITS - 1)) - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] FILT_LO  = ~FILT_HI;
   localparam logic signed [ACC_BITS-1:0] OUT_HI   =
      (ACC_BITS'(1) << (SAMPLE_BITS - 1)) - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] OUT_LO   = ~OUT_HI;

   // Clamp a wide value to the filter output range
   function automatic logic signed [FILT_BITS-1:0] sat_filt(
      input logic signed [ACC_BITS-1:0] v
   );
      logic signed [FILT_BITS-1:0] r;
      if (v > FILT_HI) begin
         r = FILT_BITS'(FILT_HI);
      end else if (v < FILT_LO) begin
         r = FILT_BITS'(FILT_LO);
      end else begin
         r = FILT_BITS'(v);
      end
      return r;
   endfunction

   // Clamp a wide value to the sample range
   function automatic logic signed [SAMPLE_BITS-1:0] sat_out(
      input logic signed [ACC_BITS-1:0] v
   );
      logic signed [SAMPLE_BITS-1:0] r;
      if (v > OUT_HI) begin
         r = SAMPLE_BITS'(OUT_HI);
      end else if (v < OUT_LO) begin
         r = SAMPLE_BITS'(OUT_LO);
      end else begin
         r = SAMPLE_BITS'(v);
      end
      return r;
   endfunction

   // Configuration registers
   logic signed [COEF_BITS-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic [GAIN_BITS-1:0]        ceil_ff, rel_ff;
   logic [MIX_BITS-1:0]         mix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff   <= B0_RESET;
         b1_ff   <= '0;
         b2_ff   <= '0;
         a1_ff   <= '0;
         a2_ff   <= '0;
         ceil_ff <= CEILING_RESET;
         rel_ff  <= RELEASE_RESET;
         mix_ff  <= MIX_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BELL_B0:        b0_ff   <= $signed(csr_wr_data);
            CSR_BELL_B1:        b1_ff   <= $signed(csr_wr_data);
            CSR_BELL_B2:        b2_ff   <= $signed(csr_wr_data);
            CSR_BELL_A1:        a1_ff   <= $signed(csr_wr_data);
            CSR_BELL_A2:        a2_ff   <= $signed(csr_wr_data);
            CSR_CEILING_LINEAR: ceil_ff <= csr_wr_data[GAIN_BITS-1:0];
            CSR_RELEASE_COEFF:  rel_ff  <= csr_wr_data[GAIN_BITS-1:0];
            CSR_WET_MIX:        mix_ff  <= csr_wr_data[MIX_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp ceiling and mix to one
   logic [GAIN_BITS-1:0] ceil_c;
   logic [MIX_BITS-1:0]  mix_c, inv_mix;
   assign ceil_c  = (ceil_ff > GAIN_ONE) ? GAIN_ONE : ceil_ff;
   assign mix_c   = (mix_ff > MIX_ONE) ? MIX_ONE : mix_ff;
   assign inv_mix = MIX_ONE - mix_c;

   // Input beat hold
   req_payload_type in_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_ff <= req_payload;
      end
   end

   // Lookahead ring: one memory holding both channels
   logic [PTR_W-1:0] pos_ff;
   logic             wrap_ff;
   logic [RAM_W-1:0] ring_rd;

   swll_ram #(
      .WIDTH(RAM_W),
      .DEPTH(LOOKAHEAD_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (cmd.out_load),
      .wr_addr(pos_ff),
      .wr_data({in_ff.audio_right, in_ff.audio_left}),
      .rd_en  (cmd.load_in),
      .rd_addr(pos_ff),
      .rd_data(ring_rd)
   );

   // Advance ring position; entries read before the first wrap are zero
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         wrap_ff <= 1'b0;
      end else if (cmd.out_load) begin
         if (pos_ff == PTR_LAST) begin
            pos_ff  <= '0;
            wrap_ff <= 1'b1;
         end else begin
            pos_ff <= pos_ff + PTR_W'(1);
         end
      end
   end

   logic signed [SAMPLE_BITS-1:0] dl, dr;
   assign dl = wrap_ff ? $signed(ring_rd[SAMPLE_BITS-1:0]) : '0;
   assign dr = wrap_ff ? $signed(ring_rd[RAM_W-1:SAMPLE_BITS]) : '0;

   // Filter history
   logic signed [SAMPLE_BITS-1:0] xl1_ff, xl2_ff, xr1_ff, xr2_ff;
   logic signed [FILT_BITS-1:0]   yl1_ff, yl2_ff, yr1_ff, yr2_ff;

   // Gain path state
   logic [GAIN_BITS-1:0]          g_ff, want_ff, d_ff;
   logic                          less_ff;
   logic signed [SAMPLE_BITS:0]   wl_ff, wr_ff;

   // Shared multiplier operand select
   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MS_B0XL:  begin mul_a = b0_ff; mul_b = MUL_B_BITS'(in_ff.side_left);  end
         MS_B1XL1: begin mul_a = b1_ff; mul_b = MUL_B_BITS'(xl1_ff);           end
         MS_B2XL2: begin mul_a = b2_ff; mul_b = MUL_B_BITS'(xl2_ff);           end
         MS_A1YL1: begin mul_a = a1_ff; mul_b = yl1_ff;                        end
         MS_A2YL2: begin mul_a = a2_ff; mul_b = yl2_ff;                        end
         MS_B0XR:  begin mul_a = b0_ff; mul_b = MUL_B_BITS'(in_ff.side_right); end
         MS_B1XR1: begin mul_a = b1_ff; mul_b = MUL_B_BITS'(xr1_ff);           end
         MS_B2XR2: begin mul_a = b2_ff; mul_b = MUL_B_BITS'(xr2_ff);           end
         MS_A1YR1: begin mul_a = a1_ff; mul_b = yr1_ff;                        end
         MS_A2YR2: begin mul_a = a2_ff; mul_b = yr2_ff;                        end
         MS_REL: begin
            mul_a = $signed({2'b00, rel_ff});
            mul_b = $signed({4'b0000, d_ff});
         end
         MS_WETL: begin
            mul_a = $signed({2'b00, g_ff});
            mul_b = MUL_B_BITS'(dl);
         end
         MS_WETR: begin
            mul_a = $signed({2'b00, g_ff});
            mul_b = MUL_B_BITS'(dr);
         end
         MS_MIXWL: begin
            mul_a = $signed({9'd0, mix_c});
            mul_b = MUL_B_BITS'(wl_ff);
         end
         MS_MIXAL: begin
            mul_a = $signed({9'd0, inv_mix});
            mul_b = MUL_B_BITS'(in_ff.audio_left);
         end
         MS_MIXWR: begin
            mul_a = $signed({9'd0, mix_c});
            mul_b = MUL_B_BITS'(wr_ff);
         end
         MS_MIXAR: begin
            mul_a = $signed({9'd0, inv_mix});
            mul_b = MUL_B_BITS'(in_ff.audio_right);
         end
         default: begin
         end
      endcase
   end

   // Product register, with the accumulate command delayed to match
   logic signed [PROD_BITS-1:0] prod_ff;
   logic [1:0]                  acc_op_ff;
   logic                        acc_ch_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_op_ff <= ACC_NONE;
         acc_ch_ff <= 1'b0;
      end else begin
         acc_op_ff <= cmd.acc_op;
         acc_ch_ff <= cmd.acc_ch;
      end
   end

   // Left and right accumulators
   logic signed [ACC_BITS-1:0] acc_l_ff, acc_r_ff, acc_sel, acc_new, prod_x;
   assign acc_sel = acc_ch_ff ? acc_r_ff : acc_l_ff;
   assign prod_x  = ACC_BITS'(prod_ff);

   always_comb begin
      case (acc_op_ff)
         ACC_LOAD: acc_new = prod_x;
         ACC_ADD:  acc_new = acc_sel + prod_x;
         ACC_SUB:  acc_new = acc_sel - prod_x;
         default:  acc_new = acc_sel;
      endcase
   end

   always_ff @(posedge clock) begin
      if (acc_op_ff != ACC_NONE) begin
         if (acc_ch_ff) begin
            acc_r_ff <= acc_new;
         end else begin
            acc_l_ff <= acc_new;
         end
      end
   end

   // Round filter sums and shift history
   logic signed [ACC_BITS-1:0] yl_sum, yr_sum;
   assign yl_sum = (acc_l_ff + FILT_RND) >>> 22;
   assign yr_sum = (acc_r_ff + FILT_RND) >>> 22;

   always_ff @(posedge clock) begin
      if (reset) begin
         xl1_ff <= '0;
         xl2_ff <= '0;
         xr1_ff <= '0;
         xr2_ff <= '0;
         yl1_ff <= '0;
         yl2_ff <= '0;
         yr1_ff <= '0;
         yr2_ff <= '0;
      end else if (cmd.filt_done) begin
         xl2_ff <= xl1_ff;
         xl1_ff <= in_ff.side_left;
         xr2_ff <= xr1_ff;
         xr1_ff <= in_ff.side_right;
         yl2_ff <= yl1_ff;
         yl1_ff <= sat_filt(yl_sum);
         yr2_ff <= yr1_ff;
         yr1_ff <= sat_filt(yr_sum);
      end
   end

   // Peak of both filter outputs, and the limit decision
   logic [FILT_BITS-1:0] mag_l, mag_r, peak_ff;
   logic                 limit_ff;
   assign mag_l = yl1_ff[FILT_BITS-1] ? FILT_BITS'(-yl1_ff) : FILT_BITS'(yl1_ff);
   assign mag_r = yr1_ff[FILT_BITS-1] ? FILT_BITS'(-yr1_ff) : FILT_BITS'(yr1_ff);

   always_ff @(posedge clock) begin
      if (cmd.peak_en) begin
         peak_ff  <= (mag_l > mag_r) ? mag_l : mag_r;
         limit_ff <= (((mag_l > mag_r) ? mag_l : mag_r) > FILT_BITS'(ceil_c));
      end
   end

   assign status.limit = limit_ff;

   // Restoring divider: ceiling * 2^23 / peak, one quotient bit a cycle
   logic [FILT_BITS-1:0] rem_ff;
   logic [GAIN_BITS-1:0] dvd_ff, quo_ff;
   logic [FILT_BITS:0]   trial;
   assign trial = {rem_ff, dvd_ff[GAIN_BITS-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= FILT_BITS'(ceil_c >> 1);
         dvd_ff <= {ceil_c[0], {(GAIN_BITS-1){1'b0}}};
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_ff << 1;
         if (trial >= {1'b0, peak_ff}) begin
            rem_ff <= FILT_BITS'(trial - {1'b0, peak_ff});
            quo_ff <= {quo_ff[GAIN_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= trial[FILT_BITS-1:0];
            quo_ff <= {quo_ff[GAIN_BITS-2:0], 1'b0};
         end
      end
   end

   // Wanted gain and its distance from the current gain
   logic [GAIN_BITS-1:0] want_c;
   assign want_c = limit_ff ? quo_ff : GAIN_ONE;

   always_ff @(posedge clock) begin
      if (cmd.want_en) begin
         want_ff <= want_c;
         less_ff <= (want_c < g_ff);
         d_ff    <= want_c - g_ff;
      end
   end

   // Drop at once, otherwise release toward the wanted gain
   logic signed [ACC_BITS-1:0] rel_sum;
   assign rel_sum = acc_l_ff + REL_RND;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_ff <= GAIN_ONE;
      end else if (cmd.gain_en) begin
         g_ff <= less_ff ? want_ff : want_ff - rel_sum[47:24];
      end
   end

   // Round the gained delayed samples
   logic signed [ACC_BITS-1:0] wl_sum, wr_sum;
   assign wl_sum = acc_l_ff + WET_RND;
   assign wr_sum = acc_r_ff + WET_RND;

   always_ff @(posedge clock) begin
      if (cmd.wet_en) begin
         wl_ff <= wl_sum[47:23];
         wr_ff <= wr_sum[47:23];
      end
   end

   // Round and saturate the mix into the output register
   logic signed [ACC_BITS-1:0] ol_sum, or_sum;
   assign ol_sum = (acc_l_ff + OUT_RND) >>> 16;
   assign or_sum = (acc_r_ff + OUT_RND) >>> 16;

   rsp_payload_type out_ff;
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.limited_left  <= sat_out(ol_sum);
         out_ff.limited_right <= sat_out(or_sum);
         out_ff.gain_applied  <= g_ff;
         out_ff.block_end_out <= in_ff.block_end;
      end
   end

   assign rsp_payload = out_ff;
endmodule

`default_nettype wire

### sv/sidechain_weighted_lookahead_limiter.sv
// Top level of the stereo sidechain-filtered lookahead peak limiter.
//
//   channel  direction  handshake          payload
//   req      in         valid/ready        audio_left/right, side_left/right, block_end
//   rsp      out        valid/ready        limited_left/right, gain_applied, block_end_out
//   csr      in         write enable only  csr_index, csr_wr_data
//
// Every item runs its 17 products through the one shared 26x28 multiplier, and an item
// whose peak is above the ceiling also runs the 24-step divider.
// One item is in work at a time; the next beat is taken while a result waits.
// A stalled result holds the last stage until the output register frees.
// Synchronous reset clears state; no clearing pass is needed for the delay ring.
`default_nettype none
`include "assert_macros.svh"

module sidechain_weighted_lookahead_limiter import swll_pkg::*; #(
   parameter int LOOKAHEAD_DEPTH = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   swll_chan_if.sink                      req_chan,
   swll_chan_if.source                    rsp_chan,
   input  wire logic                      csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wr_data
);
   swll_cmd_type    cmd;
   swll_status_type status;
   rsp_payload_type rsp_payload;
   logic            req_ready;
   logic            rsp_valid;

   swll_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_chan.ready),
      .status   (status),
      .cmd      (cmd)
   );

   swll_dp #(
      .LOOKAHEAD_DEPTH(LOOKAHEAD_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .req_payload(req_chan.payload),
      .cmd        (cmd),
      .status     (status),
      .rsp_payload(rsp_payload)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

   // Checks
   `SWLL_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.out_load, !rsp_chan.valid || rsp_chan.ready, "result overwritten while pending")
   `SWLL_ASSERT_NEXT(a_one_item, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "second beat taken during work")
   `SWLL_ASSERT_NEXT(a_result_shown, clock, reset, cmd.out_load, rsp_chan.valid, "loaded result not offered")
   `SWLL_ASSERT_NOW(a_div_when_limit, clock, reset, cmd.div_step, status.limit, "divider runs without limiting")
   `SWLL_ASSERT_NOW(a_gain_range, clock, reset, rsp_chan.valid, rsp_chan.payload.gain_applied <= GAIN_ONE, "gain above one")
endmodule

`default_nettype wire
